// ===== hw/rtl/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// scsa_pkg: shared types and constants
// Codes, register reset values and controller/datapath link structs.
// ----------------------------------------------------------------------------
package scsa_pkg;

	localparam int unsigned NUM_BUCKETS_DEF      = 32;
	localparam int unsigned TICKS_PER_SECOND_DEF = 40000;
	localparam int unsigned BUCKET_RATE_DEF      = 100;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 320;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_SAMPLE   = 2'd0,
		OP_CLEAR    = 2'd1,
		OP_RD_BKT   = 2'd2,
		OP_RD_CNT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIR_UNKNOWN = 2'd0,
		DIR_FWD     = 2'd1,
		DIR_BACK    = 2'd2,
		DIR_RSVD    = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFS_A   = 3'd0,
		CFG_OFS_B   = 3'd1,
		CFG_REV     = 3'd2,
		CFG_ENERGIZE= 3'd3,
		CFG_RELEASE = 3'd4,
		CFG_MIN_RATE= 3'd5
	} cfg_idx_t;

	localparam logic [11:0] OFS_RST      = 12'd2048;
	localparam logic [12:0] ENERGIZE_RST = 13'd150;
	localparam logic [12:0] RELEASE_RST  = 13'd50;
	localparam logic [15:0] MIN_RATE_RST = 16'd10;

	typedef struct packed {
		logic [11:0] ofs_a;
		logic [11:0] ofs_b;
		logic        rev;
		logic [12:0] energize;
		logic [12:0] release_lvl;
		logic [15:0] min_rate;
	} cfg_t;

	typedef struct packed {
		logic [63:0] tick_sum;
		logic [63:0] peak_sum;
		logic [31:0] steps;
	} bucket_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MOVE,
		ST_RETR,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_HIST_RD,
		ST_HIST_WR,
		ST_BKT_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic move_peak;
		logic move_retr;
		logic div1_start;
		logic hist_rd;
		logic hist_wr;
		logic bkt_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic hist_req;
		logic rate_ok;
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

// ===== hw/rtl/scsa_div.sv =====
// ----------------------------------------------------------------------------
// scsa_div: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module scsa_div #(
	parameter int unsigned DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);
	localparam int unsigned CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    num_q;
	logic [31:0]      den_q;
	logic [31:0]      rem_q;
	logic [32:0]      trial;
	logic             fits;

	assign trial = {rem_q, num_q[DW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q    <= dividend;
			den_q    <= divisor;
			rem_q    <= '0;
		end else if (busy) begin
			num_q    <= {num_q[DW-2:0], 1'b0};
			rem_q    <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quotient <= {quotient[DW-2:0], fits};
		end
	end
endmodule

// ===== hw/rtl/scsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsa_ctrl: operation sequencer
// Steps the datapath through evaluate, position, rate, histogram, bucket read and output phases.
// ----------------------------------------------------------------------------
module scsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  scsa_pkg::stat_t st,
	output logic            in_ready,
	output scsa_pkg::cmd_t  cmd
);
	import scsa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_fire;
				if (in_fire) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				unique case (st.op)
					OP_SAMPLE: state_d = ST_MOVE;
					OP_RD_BKT: state_d = ST_BKT_RD;
					default:   state_d = ST_OUT;
				endcase
			end
			ST_MOVE: begin
				cmd.move_peak = 1'b1;
				state_d       = ST_RETR;
			end
			ST_RETR: begin
				cmd.move_retr = 1'b1;
				state_d       = st.hist_req ? ST_DIV1_GO : ST_OUT;
			end
			ST_DIV1_GO: begin
				cmd.div1_start = 1'b1;
				state_d        = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: begin
				if (!st.div_busy) state_d = st.rate_ok ? ST_HIST_RD : ST_OUT;
			end
			ST_HIST_RD: begin
				cmd.hist_rd = 1'b1;
				state_d     = ST_HIST_WR;
			end
			ST_HIST_WR: begin
				cmd.hist_wr = 1'b1;
				state_d     = ST_OUT;
			end
			ST_BKT_RD: begin
				cmd.bkt_rd = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== hw/rtl/scsa_dp.sv =====
// ----------------------------------------------------------------------------
// scsa_dp: analyzer datapath
// Step tracking state, counters, rate divider, histogram memory, result reg.
// ----------------------------------------------------------------------------
module scsa_dp #(
	parameter int unsigned NUM_BUCKETS      = scsa_pkg::NUM_BUCKETS_DEF,
	parameter int unsigned TICKS_PER_SECOND = scsa_pkg::TICKS_PER_SECOND_DEF,
	parameter int unsigned BUCKET_RATE      = scsa_pkg::BUCKET_RATE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scsa_pkg::cmd_t                      cmd,
	input  scsa_pkg::cfg_t                      cfg,
	input  logic [scsa_pkg::IN_DATA_W-1:0]      in_data,
	input  logic [scsa_pkg::IN_USER_W-1:0]      in_user,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [scsa_pkg::OUT_DATA_W-1:0]     out_data,
	output scsa_pkg::stat_t                     st
);
	import scsa_pkg::*;

	localparam int unsigned DW = $clog2(TICKS_PER_SECOND + 1);
	localparam int unsigned IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	// bucket = rate / BUCKET_RATE as (rate * BR_MUL) >> BR_SH, exact for DW-bit rates
	localparam int unsigned     BR_SH  = DW + $clog2(BUCKET_RATE);
	localparam longint unsigned BR_MUL = ((longint'(1) << BR_SH) + longint'(BUCKET_RATE) - 1)
	                                     / longint'(BUCKET_RATE);
	localparam int unsigned     PW     = 2 * DW + 2;

	// latched item
	op_t         op_q;
	logic [11:0] ra_q, rb_q;
	logic        bad_q;
	logic [4:0]  sel_q;

	// tracking state
	logic        on_q;
	logic [1:0]  quad_q;
	dir_t        dir_q;
	logic [31:0] ticks_q;
	logic [11:0] speak_q;
	logic [31:0] pos_q, ppeak_q, retr_q, invalid_q;
	logic [31:0] total_q, err_q, rel_q;
	logic [12:0] cur_a_q, cur_b_q;
	logic        move_q, hreq_q;
	logic [31:0] hticks_q;
	logic [11:0] hpeak_q;

	// histogram
	bucket_t          mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] vld_q;
	bucket_t          rd_q;
	logic             rdv_q, sel_ok_q;
	logic [IW-1:0]    hidx_q, rd_addr, hidx_d;
	logic [PW-1:0]    bkt_prod;
	logic [DW-1:0]    bkt_idx;

	// divider
	logic          div_start, div_busy;
	logic [DW-1:0] div_num, div_q;
	logic [31:0]   div_den;

	// output
	logic        ov_q;
	logic [OUT_DATA_W-1:0] od_q;

	// sample evaluation
	logic signed [12:0] a, b;
	logic [11:0] abs_a, abs_b, peak;
	logic [12:0] sum, lvl;
	logic        now_on, good;
	logic [1:0]  quad, q_up, q_dn;
	logic        do_fwd, do_back;
	dir_t        new_dir;

	assign good  = (op_q == OP_SAMPLE) && !bad_q;
	assign a     = $signed({1'b0, ra_q}) - $signed({1'b0, cfg.ofs_a});
	assign b     = $signed({1'b0, rb_q}) - $signed({1'b0, cfg.ofs_b});
	assign abs_a = a[12] ? 12'(-a) : a[11:0];
	assign abs_b = b[12] ? 12'(-b) : b[11:0];
	assign sum   = {1'b0, abs_a} + {1'b0, abs_b};
	assign lvl   = on_q ? cfg.release_lvl : cfg.energize;
	assign now_on = sum > lvl;
	assign peak  = (abs_a > abs_b) ? abs_a : abs_b;
	assign quad  = !b[12] ? (a[12] ? 2'd1 : 2'd0) : (a[12] ? 2'd2 : 2'd3);
	assign q_up  = quad_q + 2'd1;
	assign q_dn  = quad_q - 2'd1;
	assign do_fwd  = on_q && now_on && (quad == q_up);
	assign do_back = on_q && now_on && (quad == q_dn);
	assign new_dir = do_fwd ? DIR_FWD : DIR_BACK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q      <= 1'b0;
			quad_q    <= '0;
			dir_q     <= DIR_UNKNOWN;
			ticks_q   <= '0;
			speak_q   <= '0;
			pos_q     <= '0;
			ppeak_q   <= '0;
			retr_q    <= '0;
			invalid_q <= '0;
			total_q   <= '0;
			err_q     <= '0;
			rel_q     <= '0;
			vld_q     <= '0;
			ov_q      <= 1'b0;
			move_q    <= 1'b0;
			hreq_q    <= 1'b0;
		end else begin
			if (cmd.eval) begin
				move_q <= 1'b0;
				hreq_q <= 1'b0;
				if (op_q == OP_CLEAR) begin
					pos_q     <= '0;
					ppeak_q   <= '0;
					retr_q    <= '0;
					invalid_q <= '0;
					total_q   <= '0;
					err_q     <= '0;
					rel_q     <= '0;
					vld_q     <= '0;
				end
				if (op_q == OP_SAMPLE) begin
					total_q <= total_q + 32'd1;
					if (bad_q) err_q <= err_q + 32'd1;
				end
				if (good) begin
					on_q <= now_on;
					if (!now_on) begin
						if (on_q) begin
							dir_q   <= DIR_UNKNOWN;
							ticks_q <= '0;
							rel_q   <= rel_q + 32'd1;
						end
					end else begin
						quad_q <= quad;
						if (on_q && quad == quad_q) begin
							if (ticks_q != '1) ticks_q <= ticks_q + 32'd1;
							if (peak > speak_q) speak_q <= peak;
						end else begin
							ticks_q <= 32'd1;
							speak_q <= peak;
							dir_q   <= (do_fwd || do_back) ? new_dir : DIR_UNKNOWN;
							if (do_fwd || do_back) begin
								move_q <= 1'b1;
								pos_q  <= ((do_fwd != cfg.rev)) ? pos_q + 32'd1
								                              : pos_q - 32'd1;
								hreq_q <= (dir_q == new_dir) && (ticks_q != '0);
							end else if (on_q) begin
								invalid_q <= invalid_q + 32'd1;
							end
						end
					end
				end
			end
			if (cmd.move_peak && move_q && ($signed(pos_q) > $signed(ppeak_q)))
				ppeak_q <= pos_q;
			if (cmd.move_retr && move_q && ((ppeak_q - pos_q) > retr_q))
				retr_q <= ppeak_q - pos_q;
			if (cmd.hist_wr) vld_q[hidx_q] <= 1'b1;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op_t'(in_user[1:0]);
			bad_q <= in_user[2];
			ra_q  <= in_data[11:0];
			rb_q  <= in_data[23:12];
			sel_q <= in_data[28:24];
		end
		if (cmd.eval) begin
			cur_a_q  <= good ? a : '0;
			cur_b_q  <= good ? b : '0;
			hticks_q <= ticks_q;
			hpeak_q  <= speak_q;
		end
	end

	// rate = ticks/s over step length on the divider
	assign div_start = cmd.div1_start;
	assign div_num   = DW'(TICKS_PER_SECOND);
	assign div_den   = hticks_q;

	scsa_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// bucket = rate / BUCKET_RATE by reciprocal multiply, clamped to the last bucket
	assign bkt_prod = {{(PW-DW){1'b0}}, div_q} * PW'(BR_MUL);
	assign bkt_idx  = DW'(bkt_prod >> BR_SH);
	assign hidx_d   = (32'(bkt_idx) >= 32'(NUM_BUCKETS)) ? IW'(NUM_BUCKETS - 1)
	                                                     : IW'(bkt_idx);
	assign rd_addr = cmd.hist_rd ? hidx_d : IW'(sel_q);

	always_ff @(posedge clk) begin
		if (cmd.hist_rd || cmd.bkt_rd) begin
			rd_q   <= mem[rd_addr];
			rdv_q  <= vld_q[rd_addr];
		end
		if (cmd.hist_rd) hidx_q <= hidx_d;
		if (cmd.bkt_rd) sel_ok_q <= 32'(sel_q) < 32'(NUM_BUCKETS);
		if (cmd.hist_wr) begin
			mem[hidx_q].tick_sum <= (rdv_q ? rd_q.tick_sum : 64'd0) + 64'(hticks_q);
			mem[hidx_q].peak_sum <= (rdv_q ? rd_q.peak_sum : 64'd0) + 64'(hpeak_q);
			mem[hidx_q].steps    <= (rdv_q ? rd_q.steps : 32'd0) + 32'd1;
		end
	end

	// result register
	logic [63:0] wa, wb;
	logic [31:0] wc;
	logic        bkt_hit;

	assign bkt_hit = sel_ok_q && rdv_q;

	always_comb begin
		wa = '0;
		wb = '0;
		wc = '0;
		case (op_q)
			OP_RD_BKT: begin
				if (bkt_hit) begin
					wa = rd_q.tick_sum;
					wb = rd_q.peak_sum;
					wc = rd_q.steps;
				end
			end
			OP_RD_CNT: begin
				wa = 64'(total_q);
				wb = 64'(err_q);
				wc = rel_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			od_q <= {1'b0, wc, wb, wa, invalid_q, retr_q, ppeak_q, pos_q,
			         dir_q, quad_q, on_q, cur_b_q, cur_a_q};
	end

	assign out_valid   = ov_q;
	assign out_data    = od_q;
	assign st.op       = op_q;
	assign st.hist_req = hreq_q;
	assign st.rate_ok  = 32'(div_q) >= 32'(cfg.min_rate);
	assign st.div_busy = div_busy;
	assign st.out_free = !ov_q || out_ready;
endmodule

// ===== hw/rtl/stepper_coil_current_step_analyzer_unit.sv =====
// Path to m_tvalid: a sample closing a consistent step runs one pass of the W-bit
//   one-bit-per-cycle rate divider (W = bit width of TICKS_PER_SECOND, 16 by
//   default) and a histogram read and write; a bucket read adds a memory read.
// Throughput: one item at a time; the next is taken the cycle after the result
//   is loaded into the output register. Reset clears tracking state, counters and
//   histogram valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// stepper_coil_current_step_analyzer_unit: top level
// Coil current step analyzer with speed histogram and statistics readout.
// ----------------------------------------------------------------------------
module stepper_coil_current_step_analyzer_unit #(
	parameter int unsigned NUM_BUCKETS      = scsa_pkg::NUM_BUCKETS_DEF,
	parameter int unsigned TICKS_PER_SECOND = scsa_pkg::TICKS_PER_SECOND_DEF,
	parameter int unsigned BUCKET_RATE      = scsa_pkg::BUCKET_RATE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [11:0] reading_a, [23:12] reading_b, [28:24] bucket_select, rest zero
	input  logic [scsa_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] opcode, [2] sample_bad
	input  logic [scsa_pkg::IN_USER_W-1:0]   s_tuser,
	// results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [12:0] current_a, [25:13] current_b, [26] energized, [28:27] quadrant,
	// [30:29] step_direction, [62:31] step_count, [94:63] peak_steps,
	// [126:95] worst_retraction, [158:127] bad_transitions,
	// [222:159] stat_word_a, [286:223] stat_word_b, [318:287] stat_word_c
	output logic [scsa_pkg::OUT_DATA_W-1:0]  m_tdata,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [scsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import scsa_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t st;
	logic  in_ready;

	// Register file: always ready, writes are registered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ofs_a       <= OFS_RST;
			cfg_q.ofs_b       <= OFS_RST;
			cfg_q.rev         <= 1'b0;
			cfg_q.energize    <= ENERGIZE_RST;
			cfg_q.release_lvl <= RELEASE_RST;
			cfg_q.min_rate    <= MIN_RATE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OFS_A:    cfg_q.ofs_a       <= cfg_data[11:0];
				CFG_OFS_B:    cfg_q.ofs_b       <= cfg_data[11:0];
				CFG_REV:      cfg_q.rev         <= cfg_data[0];
				CFG_ENERGIZE: cfg_q.energize    <= cfg_data[12:0];
				CFG_RELEASE:  cfg_q.release_lvl <= cfg_data[12:0];
				CFG_MIN_RATE: cfg_q.min_rate    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = in_ready;

	// Sequencer: one transfer in flight from accept to output register.
	scsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Datapath: tracking state, divider, histogram and result register.
	scsa_dp #(
		.NUM_BUCKETS      (NUM_BUCKETS),
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.BUCKET_RATE      (BUCKET_RATE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.st        (st)
	);
endmodule

// ===== tb/scsa_checker.sv =====
// ----------------------------------------------------------------------------
// scsa_checker: result predictor and scoreboard
// Tracks accepted transfers on the input, result and configuration channels,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module scsa_checker
	import scsa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,
	input  logic [IN_USER_W-1:0]   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_DATA_W-1:0]  m_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fails,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = NUM_BUCKETS_DEF;

	typedef struct packed {
		logic [12:0] cur_a;
		logic [12:0] cur_b;
		logic        en;
		logic [1:0]  quad;
		logic [1:0]  dir;
		logic [31:0] pos;
		logic [31:0] peak;
		logic [31:0] retr;
		logic [31:0] bad_tr;
		logic [63:0] wa;
		logic [63:0] wb;
		logic [31:0] wc;
	} result_t;

	result_t expected_q[$];

	// predictor copy of the configuration
	cfg_t cfg;

	// predictor copy of the state
	logic        on_flag;
	logic [1:0]  cur_quad;
	dir_t        cur_dir;
	logic [31:0] dwell_ticks;
	logic [11:0] dwell_peak;
	logic [31:0] pos, pos_peak, retr_peak, jumps;
	logic [31:0] ticks, err_ticks, releases;
	logic [63:0] hist_ticks[NB];
	logic [63:0] hist_peaks[NB];
	logic [31:0] hist_steps[NB];

	task automatic clear_stats();
		ticks = 0; err_ticks = 0; releases = 0;
		pos = 0; pos_peak = 0; retr_peak = 0; jumps = 0;
		for (int i = 0; i < NB; i++) begin
			hist_ticks[i] = 0;
			hist_peaks[i] = 0;
			hist_steps[i] = 0;
		end
	endtask

	task automatic reset_model();
		cfg = '{ofs_a: OFS_RST, ofs_b: OFS_RST, rev: 1'b0, energize: ENERGIZE_RST,
			release_lvl: RELEASE_RST, min_rate: MIN_RATE_RST};
		on_flag = 0; cur_quad = 0; cur_dir = DIR_UNKNOWN;
		dwell_ticks = 0; dwell_peak = 0;
		clear_stats();
	endtask

	// a step entered and left in the same known direction, at or above min_rate, goes to the histogram
	task automatic bin_step(dir_t entry_dir, dir_t exit_dir);
		logic [31:0] rate, idx;
		if (entry_dir != exit_dir || entry_dir == DIR_UNKNOWN || dwell_ticks == 0)
			return;
		rate = TICKS_PER_SECOND_DEF / dwell_ticks;
		if (rate < cfg.min_rate)
			return;
		idx = rate / BUCKET_RATE_DEF;
		if (idx >= NB)
			idx = NB - 1;
		hist_ticks[idx] += 64'(dwell_ticks);
		hist_peaks[idx] += 64'(dwell_peak);
		hist_steps[idx] += 1;
	endtask

	task automatic shift_position(logic fwd);
		logic [31:0] drop;
		if (fwd != cfg.rev)
			pos = pos + 1;
		else
			pos = pos - 1;
		if ($signed(pos) > $signed(pos_peak))
			pos_peak = pos;
		drop = pos_peak - pos;
		if (drop > retr_peak)
			retr_peak = drop;
	endtask

	task automatic new_step(dir_t d, logic [11:0] pk);
		cur_dir = d;
		dwell_ticks = 1;
		dwell_peak = pk;
	endtask

	task automatic track_currents(logic signed [12:0] a, logic signed [12:0] b);
		logic [12:0] abs_a, abs_b, sum, lvl;
		logic        was_on;
		logic [1:0]  q, prev_q;
		logic [11:0] pk;
		abs_a = a[12] ? -a : a;
		abs_b = b[12] ? -b : b;
		sum = abs_a + abs_b;
		was_on = on_flag;
		lvl = was_on ? cfg.release_lvl : cfg.energize;
		on_flag = sum > lvl;
		if (!on_flag) begin
			if (was_on) begin
				cur_dir = DIR_UNKNOWN;
				dwell_ticks = 0;
				releases += 1;
			end
			return;
		end
		if (!b[12])
			q = a[12] ? 2'd1 : 2'd0;
		else
			q = a[12] ? 2'd2 : 2'd3;
		pk = (abs_a > abs_b) ? abs_a[11:0] : abs_b[11:0];
		prev_q = cur_quad;
		cur_quad = q;
		if (!was_on) begin
			new_step(DIR_UNKNOWN, pk);
		end else if (q == prev_q) begin
			if (dwell_ticks != 32'hFFFF_FFFF)
				dwell_ticks += 1;
			if (pk > dwell_peak)
				dwell_peak = pk;
		end else if (q == prev_q + 2'd1) begin
			shift_position(1'b1);
			bin_step(cur_dir, DIR_FWD);
			new_step(DIR_FWD, pk);
		end else if (q == prev_q - 2'd1) begin
			shift_position(1'b0);
			bin_step(cur_dir, DIR_BACK);
			new_step(DIR_BACK, pk);
		end else begin
			jumps += 1;
			new_step(DIR_UNKNOWN, pk);
		end
	endtask

	task automatic predict_item(input op_t op, input logic [11:0] ra, input logic [11:0] rb,
			input logic bad, input logic [4:0] sel, output result_t r);
		logic signed [12:0] a, b;
		a = 0; b = 0;
		r = '0;
		case (op)
			OP_SAMPLE: begin
				ticks += 1;
				if (bad) begin
					err_ticks += 1;
				end else begin
					a = {1'b0, ra} - {1'b0, cfg.ofs_a};
					b = {1'b0, rb} - {1'b0, cfg.ofs_b};
					track_currents(a, b);
				end
			end
			OP_CLEAR: clear_stats();
			OP_RD_BKT: begin
				if (sel < NB) begin
					r.wa = hist_ticks[sel];
					r.wb = hist_peaks[sel];
					r.wc = hist_steps[sel];
				end
			end
			default: begin
				r.wa = 64'(ticks);
				r.wb = 64'(err_ticks);
				r.wc = releases;
			end
		endcase
		r.cur_a = a;
		r.cur_b = b;
		r.en = on_flag;
		r.quad = cur_quad;
		r.dir = cur_dir;
		r.pos = pos;
		r.peak = pos_peak;
		r.retr = retr_peak;
		r.bad_tr = jumps;
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t r, e;
		if (!arst_n) begin
			reset_model();
			expected_q.delete();
			fails = 0;
		end else begin
			// config writes come only while idle, so order against items is safe
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OFS_A:    cfg.ofs_a = cfg_data[11:0];
					CFG_OFS_B:    cfg.ofs_b = cfg_data[11:0];
					CFG_REV:      cfg.rev = cfg_data[0];
					CFG_ENERGIZE: cfg.energize = cfg_data[12:0];
					CFG_RELEASE:  cfg.release_lvl = cfg_data[12:0];
					CFG_MIN_RATE: cfg.min_rate = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no expected result waiting");
					fails++;
				end else begin
					e = expected_q.pop_front();
					check_field("current_a", e.cur_a, m_tdata[12:0]);
					check_field("current_b", e.cur_b, m_tdata[25:13]);
					check_field("energized", e.en, m_tdata[26]);
					check_field("quadrant", e.quad, m_tdata[28:27]);
					check_field("step_direction", e.dir, m_tdata[30:29]);
					check_field("step_count", e.pos, m_tdata[62:31]);
					check_field("peak_steps", e.peak, m_tdata[94:63]);
					check_field("worst_retraction", e.retr, m_tdata[126:95]);
					check_field("bad_transitions", e.bad_tr, m_tdata[158:127]);
					check_field("stat_word_a", e.wa, m_tdata[222:159]);
					check_field("stat_word_b", e.wb, m_tdata[286:223]);
					check_field("stat_word_c", e.wc, m_tdata[318:287]);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_item(op_t'(s_tuser[1:0]), s_tdata[11:0], s_tdata[23:12],
					s_tuser[2], s_tdata[28:24], r);
				expected_q.push_back(r);
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stepper coil current step analyzer testbench
// Drives directed and random coil sample streams, clears and reads through
// several register settings, with random idling on both sides in the first
// two; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import scsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE = 60;       // beyond the longest item latency
	localparam int HOLD_CYCLES = 400; // long receiver hold-off

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [11:0] reading_a, [23:12] reading_b,
	                                       // [28:24] bucket_select
	logic [IN_USER_W-1:0]  s_tuser = '0;   // [1:0] opcode, [2] sample_bad
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // current_a .. stat_word_c, see block
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fails, pending;
	int cycles = 0;
	int tx_idle_pct = 0;   // sender gap chance per transfer, percent
	int rx_idle_pct = 0;   // receiver stall chance per cycle, percent
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int hold_cnt = 0;

	// sender-side copy of the offsets, to build readings around zero current
	logic [11:0] ofs_a = OFS_RST, ofs_b = OFS_RST;

	// motion generator state
	logic [1:0] walk_quad = 0;
	int walk_dir = 1;
	int dwell_left = 0;

	always #5 clk = ~clk;

	stepper_coil_current_step_analyzer_unit i_dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	scsa_checker i_checker (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fails, .pending
	);

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("stepper_coil_current_step_analyzer_unit test failed");
			$finish;
		end
	end

	// one input transfer; valid stays up unless the next one idles first
	task automatic send(op_t op, logic [11:0] ra, logic [11:0] rb, logic bad,
			logic [4:0] sel);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {bad, op};
		s_tdata <= {3'b0, sel, rb, ra};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [11:0] reading(logic [11:0] ofs, int val);
		int v;
		v = int'(ofs) + val;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[11:0];
	endfunction

	// a clean sample lying in quadrant q with magnitudes in [lo, hi + 1]
	task automatic quad_sample(logic [1:0] q, int lo, int hi);
		int a, b;
		a = $urandom_range(hi, lo);
		b = $urandom_range(hi, lo);
		if (q == 2'd1 || q == 2'd2) a = -a - 1;
		if (q[1]) b = -b - 1;
		send(OP_SAMPLE, reading(ofs_a, a), reading(ofs_b, b), 1'b0, 5'($urandom_range(31)));
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_config(logic [11:0] oa, logic [11:0] ob, logic rev,
			logic [12:0] en, logic [12:0] rel, logic [15:0] rate);
		cfg_write(CFG_OFS_A, {4'b0, oa});
		cfg_write(CFG_OFS_B, {4'b0, ob});
		cfg_write(CFG_REV, {15'b0, rev});
		cfg_write(CFG_ENERGIZE, {3'b0, en});
		cfg_write(CFG_RELEASE, {3'b0, rel});
		cfg_write(CFG_MIN_RATE, rate);
		cfg_valid <= 1'b0;
		ofs_a = oa;
		ofs_b = ob;
	endtask

	// drain: all results in, then wait out work that makes no result
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly well-formed rotation with random dwell; the rest is noise
	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			if (dwell_left > 0) begin
				dwell_left--;
			end else begin
				if ($urandom_range(19) == 0) walk_dir = -walk_dir;
				walk_quad = walk_quad + ((walk_dir > 0) ? 2'd1 : 2'd3);
				dwell_left = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
			end
			quad_sample(walk_quad, 200, 2000);
		end else if (pick < 74) begin
			walk_quad = walk_quad + 2'd2;
			quad_sample(walk_quad, 200, 2000);
		end else if (pick < 79) begin
			send(OP_SAMPLE, reading(ofs_a, $urandom_range(40) - 20),
				reading(ofs_b, $urandom_range(40) - 20), 1'b0, 5'($urandom_range(31)));
		end else if (pick < 84) begin
			send(OP_SAMPLE, 12'($urandom_range(4095)), 12'($urandom_range(4095)), 1'b1,
				5'($urandom_range(31)));
		end else if (pick < 89) begin
			send(OP_SAMPLE, 12'($urandom_range(4095)), 12'($urandom_range(4095)), 1'b0,
				5'($urandom_range(31)));
		end else if (pick < 95) begin
			send(OP_RD_BKT, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
				1'($urandom_range(1)), 5'($urandom_range(31)));
		end else if (pick < 99) begin
			send(OP_RD_CNT, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
				1'($urandom_range(1)), 5'($urandom_range(31)));
		end else begin
			send(OP_CLEAR, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
				1'($urandom_range(1)), 5'($urandom_range(31)));
		end
	endtask

	initial begin
		int n_items;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			// sender 9 / receiver 87, then swapped, then no idling
			tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 87 : 0;
			rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 9 : 0;
			case (phase)
				0: set_config(12'd2048, 12'd2048, 1'b0, 13'd150, 13'd50, 16'd10);
				1: set_config(12'd0, 12'd4095, 1'b1, 13'd0, 13'd0, 16'd0);
				2: set_config(12'd4095, 12'd0, 1'b1, 13'd8190, 13'd8190, 16'd65535);
				default: set_config(12'd2000, 12'd2100, 1'b0, 13'd300, 13'd100, 16'd200);
			endcase

			if (phase == 0) begin
				// directed: reads on fresh state, field extremes, bad sample
				send(OP_RD_CNT, 12'd0, 12'd0, 1'b0, 5'd0);
				send(OP_RD_BKT, 12'd4095, 12'd4095, 1'b1, 5'd31);
				send(OP_SAMPLE, 12'd4095, 12'd4095, 1'b1, 5'd31);
				send(OP_SAMPLE, 12'd0, 12'd0, 1'b0, 5'd0);
				send(OP_SAMPLE, 12'd4095, 12'd4095, 1'b0, 5'd0);
				send(OP_SAMPLE, 12'd2048, 12'd2048, 1'b0, 5'd0);
				// forward walk, one-tick steps land in the last bucket
				for (int i = 0; i < 6; i++)
					quad_sample(i[1:0], 500, 1500);
				// backward walk with a dwell
				for (int i = 0; i < 3; i++) begin
					quad_sample(2'(5 - 1 - i), 500, 1500);
					quad_sample(2'(5 - 1 - i), 500, 1500);
				end
				quad_sample(2'd0, 500, 1500);   // jump by two quadrants
				send(OP_SAMPLE, 12'd2048, 12'd2048, 1'b0, 5'd3); // release
				send(OP_RD_BKT, 12'd0, 12'd0, 1'b0, 5'd31);
				send(OP_RD_CNT, 12'd0, 12'd0, 1'b0, 5'd0);
				send(OP_CLEAR, 12'd0, 12'd0, 1'b0, 5'd0);
				send(OP_RD_CNT, 12'd0, 12'd0, 1'b0, 5'd0);
				// long hold-off on the receiver while items keep coming
				hold_req <= 1'b1;
			end

			n_items = (phase == 0 || phase == 3) ? 260 : 100;
			for (int i = 0; i < n_items; i++)
				random_item();
			settle();
		end

		if (fails == 0)
			$display("stepper_coil_current_step_analyzer_unit test passed");
		else
			$display("stepper_coil_current_step_analyzer_unit test failed");
		$finish;
	end

endmodule
